/* sv/wall_texel_address_unit_assert.svh */
// assertion macros shared by the checker
`ifndef WALL_TEXEL_ADDRESS_UNIT_ASSERT_SVH
`define WALL_TEXEL_ADDRESS_UNIT_ASSERT_SVH

// same-cycle implication, held off during reset
`define WTA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wall texel address check failed");

// next-cycle implication, held off during reset
`define WTA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wall texel address check failed");

// next-cycle implication that also covers reset itself
`define WTA_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("wall texel address reset check failed");

`endif

/* sv/wta_pkg.sv */
package wta_pkg;

  // texture geometry
  localparam int TEX_SIZE    = 64;
  localparam int TEX_BITS    = 6;
  localparam int SCREEN_ROWS = 1024;

  // widths of the row arithmetic
  localparam int D_W   = 23;          // signed row position
  localparam int REM_W = D_W - 1;     // non-negative part of it
  localparam int LH_W  = 16;
  localparam int OFS_W = 23;
  localparam int CFG_IDX_W = 2;

  // half screen, scaled by the texture size
  localparam logic [D_W-1:0] ROW_OFS = D_W'(SCREEN_ROWS * TEX_SIZE / 2);

  // saturated row
  localparam logic [TEX_BITS-1:0] TEX_MAX = TEX_BITS'(TEX_SIZE - 1);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLAYER_X        = 2'd0,
    CFG_PLAYER_Y        = 2'd1,
    CFG_ROW_PITCH       = 2'd2,
    CFG_BYTES_PER_TEXEL = 2'd3
  } cfg_idx_t;

  // texture codes
  typedef enum logic [1:0] {
    TEX_NORTH = 2'd0,
    TEX_SOUTH = 2'd1,
    TEX_WEST  = 2'd2,
    TEX_EAST  = 2'd3
  } tex_sel_t;

  // one restoring division step
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic             q;
  } dstep_t;

  function automatic dstep_t div_step(input logic [REM_W-1:0] rem,
                                      input logic [REM_W-1:0] dvs);
    dstep_t res;
    if (rem >= dvs) begin
      res.rem = rem - dvs;
      res.q   = 1'b1;
    end else begin
      res.rem = rem;
      res.q   = 1'b0;
    end
    return res;
  endfunction

endpackage

/* sv/wall_texel_address_unit.sv */
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  hit_side, ray dirs, distance, height, row
// out      output     out_valid/out_stall  texture select, texel column/row, offset
// cfg      input      cfg_we               cfg_index, cfg_data
//
// one wall pixel per clock while no stall holds the output
// the five stages are prepare/multiply, then three stages of the six-bit
// restoring row division (two quotient bits each, the first with the
// overflow test), then the byte offset products into the output register
// synchronous active-low reset clears the valid bits and restores the config registers
// a stall at the output freezes every stage together and is fed back as in_stall
module wall_texel_address_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_hit_side,
  input  logic signed [17:0]                   in_ray_dir_x,
  input  logic signed [17:0]                   in_ray_dir_y,
  input  logic [31:0]                          in_wall_distance,
  input  logic [wta_pkg::LH_W-1:0]             in_slice_height,
  input  logic [9:0]                           in_row,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output wta_pkg::tex_sel_t                    out_texture_select,
  output logic [wta_pkg::TEX_BITS-1:0]         out_texel_column,
  output logic [wta_pkg::TEX_BITS-1:0]         out_texel_row,
  output logic [wta_pkg::OFS_W-1:0]            out_byte_offset,
  input  logic                                 cfg_we,
  input  logic [wta_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [31:0]                          cfg_data
);
  import wta_pkg::*;

  // configuration registers
  logic [31:0] player_x_r, player_y_r;
  logic [15:0] row_pitch_r;
  logic [2:0]  bpt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      player_x_r  <= '0;
      player_y_r  <= '0;
      row_pitch_r <= 16'd256;
      bpt_r       <= 3'd4;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PLAYER_X:        player_x_r  <= cfg_data;
        CFG_PLAYER_Y:        player_y_r  <= cfg_data;
        CFG_ROW_PITCH:       row_pitch_r <= cfg_data[15:0];
        CFG_BYTES_PER_TEXEL: bpt_r       <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves unless the output transaction is held
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: texture choice, wall hit fraction, row position
  logic signed [17:0] dir_sel;
  logic signed [50:0] prod;
  logic [31:0]        pos_sel, frac;
  logic               mirror;
  logic [D_W-1:0]     d_pos;
  tex_sel_t           sel_nxt;

  assign dir_sel = in_hit_side ? in_ray_dir_x : in_ray_dir_y;
  assign pos_sel = in_hit_side ? player_x_r : player_y_r;
  assign prod    = $signed({1'b0, in_wall_distance}) * dir_sel;
  assign frac    = {pos_sel[15:0], 16'd0} + prod[31:0];
  assign mirror  = in_hit_side ? in_ray_dir_y[17]
                               : (!in_ray_dir_x[17] && (in_ray_dir_x != '0));
  assign d_pos   = {7'd0, in_row, 6'd0} + {2'd0, in_slice_height, 5'd0} - ROW_OFS;

  always_comb begin
    if (in_hit_side) sel_nxt = in_ray_dir_y[17] ? TEX_NORTH : TEX_SOUTH;
    else             sel_nxt = in_ray_dir_x[17] ? TEX_WEST : TEX_EAST;
  end

  logic                v1_r, v2_r, v3_r, v4_r;
  tex_sel_t            sel1_r, sel2_r, sel3_r, sel4_r;
  logic [TEX_BITS-1:0] col1_r, col2_r, col3_r, col4_r;
  logic                zero1_r, zero2_r, zero3_r;
  logic                sat2_r, sat3_r;
  logic [REM_W-1:0]    rem1_r, rem2_r, rem3_r;
  logic [LH_W-1:0]     lh1_r, lh2_r, lh3_r;
  logic [1:0]          q2_r;
  logic [3:0]          q3_r;
  logic [TEX_BITS-1:0] trow4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r    <= in_valid;
      sel1_r  <= sel_nxt;
      col1_r  <= frac[31 -: TEX_BITS] ^ {TEX_BITS{mirror}};
      zero1_r <= d_pos[D_W-1] && (in_slice_height != '0);
      rem1_r  <= d_pos[REM_W-1:0];
      lh1_r   <= in_slice_height;
    end
  end

  // stage 2: overflow test, quotient bits 5 and 4
  dstep_t s5, s4;
  logic   ovf;
  assign ovf = rem1_r >= {lh1_r, 6'd0};
  assign s5  = div_step(rem1_r, REM_W'({6'd0, lh1_r} << 5));
  assign s4  = div_step(s5.rem, REM_W'({6'd0, lh1_r} << 4));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r    <= v1_r;
      sel2_r  <= sel1_r;
      col2_r  <= col1_r;
      zero2_r <= zero1_r;
      sat2_r  <= !zero1_r && ovf;
      rem2_r  <= s4.rem;
      lh2_r   <= lh1_r;
      q2_r    <= {s5.q, s4.q};
    end
  end

  // stage 3: quotient bits 3 and 2
  dstep_t s3, s2;
  assign s3 = div_step(rem2_r, REM_W'({6'd0, lh2_r} << 3));
  assign s2 = div_step(s3.rem, REM_W'({6'd0, lh2_r} << 2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r    <= v2_r;
      sel3_r  <= sel2_r;
      col3_r  <= col2_r;
      zero3_r <= zero2_r;
      sat3_r  <= sat2_r;
      rem3_r  <= s2.rem;
      lh3_r   <= lh2_r;
      q3_r    <= {q2_r, s3.q, s2.q};
    end
  end

  // stage 4: quotient bits 1 and 0, clamp to the texture
  dstep_t s1, s0;
  logic [TEX_BITS-1:0] trow_nxt;
  assign s1 = div_step(rem3_r, REM_W'({6'd0, lh3_r} << 1));
  assign s0 = div_step(s1.rem, REM_W'({6'd0, lh3_r}));

  always_comb begin
    if (zero3_r)     trow_nxt = '0;
    else if (sat3_r) trow_nxt = TEX_MAX;
    else             trow_nxt = {q3_r, s1.q, s0.q};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r    <= v3_r;
      sel4_r  <= sel3_r;
      col4_r  <= col3_r;
      trow4_r <= trow_nxt;
    end
  end

  // stage 5: byte offset into the output register
  logic [21:0]      row_bytes;
  logic [8:0]       col_bytes;
  logic [OFS_W-1:0] ofs_nxt;
  assign row_bytes = trow4_r * row_pitch_r;
  assign col_bytes = col4_r * bpt_r;
  assign ofs_nxt   = OFS_W'(row_bytes) + OFS_W'(col_bytes);

  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r        <= v4_r;
      out_texture_select <= sel4_r;
      out_texel_column   <= col4_r;
      out_texel_row      <= trow4_r;
      out_byte_offset    <= ofs_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* sv/wta_checker.sv */
`include "wall_texel_address_unit_assert.svh"

module wta_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall
);

  // a held result stays offered
  `WTA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // input is held back only by a held output transaction
  `WTA_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

  // an accepted transaction reaches the output when no stall holds the pipeline on its way
  `WTA_ASSERT_NEXT(a_latency,
    (in_valid && !in_stall) ##1 !in_stall ##1 !in_stall ##1 !in_stall ##1 !in_stall,
    out_valid)

  // reset empties the pipeline
  `WTA_ASSERT_RST(a_reset_empty, !rst_n, !out_valid)

endmodule

bind wall_texel_address_unit wta_checker u_wta_checker (.*);
